### design/cc20_pkg.sv
package cc20_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    localparam int unsigned DROUNDS = 10;
    localparam int unsigned DROUND_W = $clog2(DROUNDS);

    localparam logic [3:0][31:0] SIGMA = {
        32'h6b206574, 32'h79622d32, 32'h3320646e, 32'h61707865
    };

    localparam int unsigned CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_01,
        CFG_KEY_23,
        CFG_KEY_45,
        CFG_KEY_67,
        CFG_NONCE_01,
        CFG_NONCE_2,
        CFG_START_CTR
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0][31:0] key;
        logic [2:0][31:0] nonce;
        logic [31:0]      start_ctr;
    } t_cfg;

    // one queued byte request, tagged by the front end
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic [5:0] pos;
        logic       start;
    } t_entry;

    function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned s);
        return (v << s) | (v >> (32 - s));
    endfunction

endpackage

### design/cc20_front.sv
module cc20_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [7:0]       i_data_byte,
    input  logic             i_last_byte,
    output logic             o_ent_valid,
    input  logic             i_ent_ready,
    output cc20_pkg::t_entry o_ent
);
    import cc20_pkg::*;

    logic [5:0] r_pos;
    logic       r_in_msg;
    logic       accept;

    assign o_ent_valid = i_in_valid;
    assign o_in_ready  = i_ent_ready;
    assign accept      = i_in_valid && i_ent_ready;

    always_comb begin
        o_ent.data  = i_data_byte;
        o_ent.last  = i_last_byte;
        o_ent.pos   = r_pos;
        o_ent.start = !r_in_msg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_in_msg <= 1'b0;
        end else if (accept) begin
            r_pos    <= i_last_byte ? 6'd0 : r_pos + 6'd1;
            r_in_msg <= !i_last_byte;
        end
    end

endmodule

### design/cc20_queue.sv
module cc20_queue #(
    parameter int unsigned DEPTH = cc20_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_valid,
    output logic             o_wr_ready,
    input  cc20_pkg::t_entry i_wr_entry,
    output logic             o_rd_valid,
    input  logic             i_rd_ready,
    output cc20_pkg::t_entry o_rd_entry
);
    import cc20_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_entry          r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            push;
    logic            pop;

    assign o_wr_ready = r_count != CW'(DEPTH);
    assign o_rd_valid = r_count != '0;
    assign o_rd_entry = r_mem[r_rd_ptr];
    assign push       = i_wr_valid && o_wr_ready;
    assign pop        = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_wr_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### design/cc20_back.sv
module cc20_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  cc20_pkg::t_cfg   i_cfg,
    input  logic             i_ent_valid,
    output logic             o_ent_ready,
    input  cc20_pkg::t_entry i_ent,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [7:0]       o_out_byte,
    output logic             o_out_last
);
    import cc20_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_ROUND, ST_FINAL, ST_EMIT} t_state;

    // add/xor/rotate steps of a quarter round
    localparam logic [1:0] STEP_AD16 = 2'd0;
    localparam logic [1:0] STEP_CB12 = 2'd1;
    localparam logic [1:0] STEP_AD8  = 2'd2;
    localparam logic [1:0] STEP_CB7  = 2'd3;

    t_state               r_state;
    logic [3:0][31:0]     r_a, r_b, r_c, r_d;
    logic [3:0][31:0]     n_a, n_b, n_c, n_d;
    logic [15:0][31:0]    r_ks;
    logic [31:0]          r_ctr;
    logic [1:0]           r_step;
    logic                 r_diag;
    logic [DROUND_W-1:0]  r_dround;
    t_entry               r_ent;
    logic                 r_out_valid;
    logic [7:0]           r_out_byte;
    logic                 r_out_last;

    logic                 out_free;
    logic                 head_new;
    logic                 pop;
    logic                 emit;
    logic [31:0]          ctr_use;
    logic [3:0][31:0]     init_d;

    function automatic logic [7:0] ks_byte(input logic [15:0][31:0] ks,
                                           input logic [5:0] pos);
        logic [31:0] w;
        w = ks[pos[5:2]] >> {pos[1:0], 3'b000};
        return w[7:0];
    endfunction

    assign out_free    = !r_out_valid || i_out_ready;
    assign head_new    = i_ent.pos == 6'd0;
    assign o_ent_ready = (r_state == ST_IDLE) && (head_new || out_free);
    assign pop         = i_ent_valid && o_ent_ready;
    assign emit        = (pop && !head_new) || ((r_state == ST_EMIT) && out_free);
    assign ctr_use     = i_ent.start ? i_cfg.start_ctr : r_ctr;
    assign init_d      = {i_cfg.nonce, r_ctr};

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_last  = r_out_last;

    // four quarter rounds side by side, one add per lane each cycle
    always_comb begin
        logic [1:0]  ib, ic, id;
        logic [31:0] sum;
        n_a = r_a;
        n_b = r_b;
        n_c = r_c;
        n_d = r_d;
        for (int k = 0; k < 4; k++) begin
            ib = 2'(k) + {1'b0, r_diag};
            ic = 2'(k) + {r_diag, 1'b0};
            id = 2'(k) + {r_diag, r_diag};
            case (r_step)
                STEP_AD16: begin
                    sum = r_a[k] + r_b[ib];
                    n_a[k] = sum;
                    n_d[id] = rotl(r_d[id] ^ sum, 16);
                end
                STEP_CB12: begin
                    sum = r_c[ic] + r_d[id];
                    n_c[ic] = sum;
                    n_b[ib] = rotl(r_b[ib] ^ sum, 12);
                end
                STEP_AD8: begin
                    sum = r_a[k] + r_b[ib];
                    n_a[k] = sum;
                    n_d[id] = rotl(r_d[id] ^ sum, 8);
                end
                STEP_CB7: begin
                    sum = r_c[ic] + r_d[id];
                    n_c[ic] = sum;
                    n_b[ib] = rotl(r_b[ib] ^ sum, 7);
                end
                default: begin
                    sum = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_ctr       <= '0;
        end else begin
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (pop) begin
                        if (head_new) begin
                            r_ent    <= i_ent;
                            r_a      <= SIGMA;
                            r_b      <= i_cfg.key[3:0];
                            r_c      <= i_cfg.key[7:4];
                            r_d      <= {i_cfg.nonce, ctr_use};
                            r_ctr    <= ctr_use;
                            r_step   <= STEP_AD16;
                            r_diag   <= 1'b0;
                            r_dround <= '0;
                            r_state  <= ST_ROUND;
                        end else begin
                            r_out_byte  <= i_ent.data ^ ks_byte(r_ks, i_ent.pos);
                            r_out_last  <= i_ent.last;
                        end
                    end
                end
                ST_ROUND: begin
                    r_a    <= n_a;
                    r_b    <= n_b;
                    r_c    <= n_c;
                    r_d    <= n_d;
                    r_step <= r_step + 2'd1;
                    if (r_step == STEP_CB7) begin
                        r_diag <= ~r_diag;
                        if (r_diag) begin
                            r_dround <= r_dround + 1'b1;
                            if (r_dround == DROUND_W'(DROUNDS - 1)) begin
                                r_state <= ST_FINAL;
                            end
                        end
                    end
                end
                ST_FINAL: begin
                    for (int k = 0; k < 4; k++) begin
                        r_ks[k]      <= r_a[k] + SIGMA[k];
                        r_ks[4 + k]  <= r_b[k] + i_cfg.key[k];
                        r_ks[8 + k]  <= r_c[k] + i_cfg.key[4 + k];
                        r_ks[12 + k] <= r_d[k] + init_d[k];
                    end
                    r_ctr   <= r_ctr + 32'd1;
                    r_state <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (out_free) begin
                        r_out_byte  <= r_ent.data ^ ks_byte(r_ks, r_ent.pos);
                        r_out_last  <= r_ent.last;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

### design/chacha20_stream_cipher_core.sv
// Channel | Direction | Handshake                | Payload
// input   | in        | i_in_valid / o_in_ready   | i_data_byte, i_last_byte
// output  | out       | o_out_valid / i_out_ready | o_out_byte, o_out_last
// config  | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// A byte inside a keystream block passes through a queue entry and the output
// register, and the core sustains one byte per cycle for those bytes while the
// output is not stalled. The first byte of each 64-byte block runs the round
// engine (10 double rounds x 2 halves x 4 add steps, one adder per lane), then
// the final add, then the emit. A small request queue keeps taking bytes while
// the engine runs, until it fills; reset is synchronous, active low, and clears
// the queue, message state and config registers. Config writes are taken every cycle.
module chacha20_stream_cipher_core #(
    parameter int unsigned QUEUE_DEPTH = cc20_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [7:0]                     i_data_byte,
    input  logic                           i_last_byte,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [7:0]                     o_out_byte,
    output logic                           o_out_last,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [cc20_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]                    i_cfg_data
);
    import cc20_pkg::*;

    t_cfg   r_cfg;
    t_entry fe_ent;
    t_entry q_ent;
    logic   fe_valid;
    logic   fe_ready;
    logic   q_valid;
    logic   q_ready;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_KEY_01:    r_cfg.key[1:0]   <= i_cfg_data;
                CFG_KEY_23:    r_cfg.key[3:2]   <= i_cfg_data;
                CFG_KEY_45:    r_cfg.key[5:4]   <= i_cfg_data;
                CFG_KEY_67:    r_cfg.key[7:6]   <= i_cfg_data;
                CFG_NONCE_01:  r_cfg.nonce[1:0] <= i_cfg_data;
                CFG_NONCE_2:   r_cfg.nonce[2]   <= i_cfg_data[31:0];
                CFG_START_CTR: r_cfg.start_ctr  <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    cc20_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_ent_valid (fe_valid),
        .i_ent_ready (fe_ready),
        .o_ent       (fe_ent)
    );

    cc20_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (fe_valid),
        .o_wr_ready (fe_ready),
        .i_wr_entry (fe_ent),
        .o_rd_valid (q_valid),
        .i_rd_ready (q_ready),
        .o_rd_entry (q_ent)
    );

    cc20_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_ent_valid (q_valid),
        .o_ent_ready (q_ready),
        .i_ent       (q_ent),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_byte  (o_out_byte),
        .o_out_last  (o_out_last)
    );

endmodule

### design/cc20_checker.sv
module cc20_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_out_byte,
    input logic       o_out_last
);
    logic [3:0] r_pend;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = i_in_valid && o_in_ready;
    assign out_acc = o_out_valid && i_out_ready;

    // requests taken but not yet answered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else if (in_acc && !out_acc) begin
            r_pend <= r_pend + 4'd1;
        end else if (out_acc && !in_acc) begin
            r_pend <= r_pend - 4'd1;
        end
    end

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_no_spurious_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_pend != 4'd0)
        else $error("output without a pending request");

    a_out_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output valid dropped while stalled");

    a_out_data_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_byte) && $stable(o_out_last))
        else $error("output payload changed while stalled");

endmodule

bind chacha20_stream_cipher_core cc20_checker u_cc20_checker (.*);
